FILE: rtl/core/rau_pkg.sv
// Package for the rational arithmetic unit: types, codes and constants.
`default_nettype none
package rau_pkg;
	localparam int DataWidthDef = 32;

	typedef enum logic [2:0] {
		MODE_ADD = 3'd0,
		MODE_SUB = 3'd1,
		MODE_MUL = 3'd2,
		MODE_DIV = 3'd3,
		MODE_CMP = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		ORD_LESS    = 2'd0,
		ORD_EQUAL   = 2'd1,
		ORD_GREATER = 2'd2
	} order_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_ZERODEN = 2'd1,
		ST_DIVZERO = 2'd2,
		ST_OVF     = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [31:0] a_num;
		logic signed [31:0] a_den;
		logic signed [31:0] b_num;
		logic signed [31:0] b_den;
	} in_req_t;

	typedef struct packed {
		logic signed [31:0] res_num;
		logic [30:0]        res_den;
		logic [1:0]         order;
		logic [1:0]         status;
	} out_req_t;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_PREP,
		S_GCD,
		S_DIVN,
		S_DIVD,
		S_DONE
	} seq_state_t;

	// divider command and status
	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;
endpackage
`default_nettype wire

FILE: rtl/core/rau_divider.sv
// Shared restoring divider for 64-bit magnitudes, one quotient bit a cycle.
`default_nettype none
module rau_divider
	import rau_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire div_ctl_t    ctl,
	input  wire logic [63:0] dividend,
	input  wire logic [63:0] divisor,
	output div_sts_t         sts,
	output logic [63:0]      quotient,
	output logic [63:0]      remainder
);
	logic [63:0] quo_q;
	logic [63:0] rem_q;
	logic [63:0] dsr_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] trial;
	logic [64:0] shifted;

	// shift in the next dividend bit and try a subtract
	always_comb begin
		shifted = {rem_q, quo_q[63]};
		trial   = shifted - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted[63:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign sts.busy  = busy_q;
	assign sts.done  = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

	// a finished division leaves the remainder below the divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q && dsr_q != 64'd0 |-> rem_q < dsr_q)
		else $error("divider remainder not below divisor");
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != 7'd0)
		else $error("divider count ran out while busy");
endmodule
`default_nettype wire

FILE: rtl/core/rational_arithmetic_unit.sv
// Rational arithmetic unit: fraction add, subtract, multiply, divide, compare.
// Every request takes four shared 32x32 multiplies; an arithmetic request with a
// nonzero numerator and no error then takes k GCD steps (up to ~93) of one restoring
// division each, then two more divisions that reduce numerator and denominator.
// Throughput: one request at a time; in_ready is low until the result is taken.
// Reset: arst_n clears the sequencer and the output valid flag; payloads are not reset.
`default_nettype none
module rational_arithmetic_unit
	import rau_pkg::*;
#(
	parameter int DATA_WIDTH = DataWidthDef
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_req_t  in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output out_req_t      out_data
);
	localparam int W = DATA_WIDTH;

	seq_state_t state_q, state_d;
	logic [2:0]   mode_q;
	logic [W-1:0] anm_q, adm_q, bnm_q, bdm_q;
	logic         sa_q, sb_q;
	logic [1:0]   mcnt_q;
	logic [63:0]  x_q, y_q, p_q;
	logic [63:0]  num_q, den_q, g0_q, g1_q, nm_q;
	logic         neg_q;
	logic         out_valid_q;
	out_req_t     out_q;

	logic [W-1:0] an_mag, ad_mag, bn_mag, bd_mag;
	logic         an_neg, ad_neg, bn_neg, bd_neg;
	logic [W-1:0] m_a, m_b;
	logic [63:0]  prod;
	logic [63:0]  sum_mag;
	logic         sum_neg;
	logic         y_neg_eff;
	logic [1:0]   ord_cmp;
	logic [63:0]  num_sel;

	div_ctl_t    dctl;
	div_sts_t    dsts;
	logic [63:0] d_dividend, d_divisor, d_quo, d_rem;

	// operand decode: sign and magnitude of the low W bits
	function automatic logic [W-1:0] magof(input logic [31:0] v);
		logic [W-1:0] t;
		t = v[W-1:0];
		return t[W-1] ? (~t + 1'b1) : t;
	endfunction

	always_comb begin
		an_neg = in_data.a_num[W-1];
		ad_neg = in_data.a_den[W-1];
		bn_neg = in_data.b_num[W-1];
		bd_neg = in_data.b_den[W-1];
		an_mag = magof(in_data.a_num);
		ad_mag = magof(in_data.a_den);
		bn_mag = magof(in_data.b_num);
		bd_mag = magof(in_data.b_den);
	end

	// one shared multiplier, operands chosen by the step count
	always_comb begin
		m_a = anm_q;
		m_b = bdm_q;
		case (mcnt_q)
			2'd0: begin m_a = anm_q; m_b = bdm_q; end
			2'd1: begin m_a = bnm_q; m_b = adm_q; end
			2'd2: begin
				m_a = adm_q;
				m_b = (mode_q == MODE_DIV) ? bnm_q : bdm_q;
			end
			default: begin m_a = anm_q; m_b = bnm_q; end
		endcase
		prod = 64'(m_a) * 64'(m_b);
	end

	// signed sum of cross products for add and subtract, and their order for compare
	always_comb begin
		y_neg_eff = (mode_q == MODE_SUB) ? (!sb_q && y_q != 64'd0) : sb_q;
		if (sa_q == y_neg_eff) begin
			sum_neg = sa_q;
			sum_mag = x_q + y_q;
		end else if (x_q >= y_q) begin
			sum_neg = sa_q;
			sum_mag = x_q - y_q;
		end else begin
			sum_neg = y_neg_eff;
			sum_mag = y_q - x_q;
		end
		if (x_q == y_q) begin
			ord_cmp = ORD_EQUAL;
			if (sa_q != sb_q && x_q != 64'd0) ord_cmp = sa_q ? ORD_LESS : ORD_GREATER;
		end else if (sa_q != sb_q) begin
			ord_cmp = sa_q ? ORD_LESS : ORD_GREATER;
		end else if (x_q < y_q) begin
			ord_cmp = sa_q ? ORD_GREATER : ORD_LESS;
		end else begin
			ord_cmp = sa_q ? ORD_LESS : ORD_GREATER;
		end
	end

	// unreduced numerator magnitude of the current mode
	always_comb begin
		num_sel = (mode_q == MODE_MUL) ? p_q :
			((mode_q == MODE_DIV) ? x_q : sum_mag);
	end

	rau_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (dctl),
		.dividend  (d_dividend),
		.divisor   (d_divisor),
		.sts       (dsts),
		.quotient  (d_quo),
		.remainder (d_rem)
	);

	// divider operands for the division that starts this cycle
	always_comb begin
		d_dividend = num_sel;
		d_divisor  = den_q;
		case (state_q)
			S_GCD: begin
				if (d_rem == 64'd0) begin
					// GCD found: reduce the numerator next
					d_dividend = num_q;
					d_divisor  = g1_q;
				end else begin
					d_dividend = g1_q;
					d_divisor  = d_rem;
				end
			end
			S_DIVN: begin
				d_dividend = den_q;
				d_divisor  = g0_q;
			end
			default: ;
		endcase
	end

	logic         is_arith;
	logic         fits;
	logic [63:0]  lim;
	logic [31:0]  rn_val;
	logic [31:0]  ext_num;

	assign is_arith = (mode_q == MODE_ADD) || (mode_q == MODE_SUB) ||
		(mode_q == MODE_MUL) || (mode_q == MODE_DIV);
	assign lim = 64'd1 << (W - 1);
	assign fits = (d_quo <= lim - 64'd1) &&
		(neg_q ? (nm_q <= lim) : (nm_q <= lim - 64'd1));
	always_comb begin
		rn_val  = neg_q ? (32'd0 - nm_q[31:0]) : nm_q[31:0];
		ext_num = rn_val;
	end

	// sequencer next state
	always_comb begin
		state_d     = state_q;
		dctl.start  = 1'b0;
		case (state_q)
			S_IDLE: if (in_valid && in_ready) state_d = S_MUL;
			S_MUL: if (mcnt_q == 2'd3) state_d = S_PREP;
			S_PREP: begin
				if (is_arith && out_q.status == ST_OK && num_sel != 64'd0 &&
					!(mode_q == MODE_DIV && bnm_q == '0)) begin
					state_d    = S_GCD;
					dctl.start = 1'b1;
				end else begin
					state_d = S_DONE;
				end
			end
			S_GCD: if (dsts.done) begin
				if (d_rem == 64'd0) begin
					state_d    = S_DIVN;
					dctl.start = 1'b1;
				end else begin
					dctl.start = 1'b1;
				end
			end
			S_DIVN: if (dsts.done) begin
				state_d    = S_DIVD;
				dctl.start = 1'b1;
			end
			S_DIVD: if (dsts.done) state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			mcnt_q      <= '0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (state_q == S_DONE) out_valid_q <= 1'b1;
			if (state_q == S_IDLE) mcnt_q <= '0;
			else if (state_q == S_MUL) mcnt_q <= mcnt_q + 2'd1;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (in_valid && in_ready) begin
				mode_q <= in_data.mode;
				anm_q  <= an_mag;
				adm_q  <= ad_mag;
				bnm_q  <= bn_mag;
				bdm_q  <= bd_mag;
				sa_q   <= (an_neg != ad_neg) && an_mag != '0;
				sb_q   <= (bn_neg != bd_neg) && bn_mag != '0;
				out_q.status <= (ad_mag == '0 || bd_mag == '0) ? ST_ZERODEN : ST_OK;
			end
			S_MUL: begin
				case (mcnt_q)
					2'd0: x_q <= prod;
					2'd1: y_q <= prod;
					2'd2: den_q <= prod;
					default: p_q <= prod;
				endcase
			end
			S_PREP: begin
				out_q.res_num <= '0;
				out_q.res_den <= '0;
				out_q.order   <= ORD_EQUAL;
				if (mode_q == MODE_ADD || mode_q == MODE_SUB) begin
					num_q <= sum_mag;
					neg_q <= sum_mag != 64'd0 && sum_neg;
				end else if (mode_q == MODE_MUL) begin
					num_q <= p_q;
					neg_q <= sa_q != sb_q;
				end else begin
					num_q <= x_q;
					neg_q <= sa_q != sb_q;
				end
				g0_q <= (mode_q == MODE_MUL) ? p_q :
					((mode_q == MODE_DIV) ? x_q : sum_mag);
				g1_q <= den_q;
				if (out_q.status == ST_OK) begin
					if (!is_arith) out_q.order <= ord_cmp;
					else if (mode_q == MODE_DIV && bnm_q == '0)
						out_q.status <= ST_DIVZERO;
					else if (((mode_q == MODE_MUL) ? p_q : ((mode_q == MODE_DIV) ?
						x_q : sum_mag)) == 64'd0)
						out_q.res_den <= 31'd1;
				end
			end
			S_GCD: if (dsts.done) begin
				if (d_rem == 64'd0) g0_q <= g1_q;
				else begin
					g0_q <= g1_q;
					g1_q <= d_rem;
				end
			end
			S_DIVN: if (dsts.done) nm_q <= d_quo;
			S_DIVD: if (dsts.done) begin
				if (fits) begin
					out_q.res_num <= ext_num;
					out_q.res_den <= d_quo[30:0];
				end else begin
					out_q.status <= ST_OVF;
				end
			end
			default: ;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// sequencing checks
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !in_ready)
		else $error("ready while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |=> out_valid)
		else $error("result not presented");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.res_den == 31'd0)
		else $error("error result carries a denominator");
endmodule
`default_nettype wire

FILE: tb/sv/rational_arithmetic_unit_test.sv
// Testbench for the rational arithmetic unit: directed and random fraction requests.
`timescale 1ns / 100ps
`default_nettype none
module rational_arithmetic_unit_test;
	import rau_pkg::*;

	localparam int DW = DataWidthDef;
	localparam int WATCHDOG_LIMIT = 40000;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	in_req_t  in_data;
	logic     out_valid;
	logic     out_ready;
	out_req_t out_data;

	out_req_t expected_results[$];
	int       failures;
	int       quiet_cycles;
	int       out_stall;
	bit       no_idle;

	rational_arithmetic_unit #(.DATA_WIDTH(DW)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// split a DW-bit two's complement field into sign and magnitude
	function automatic logic [63:0] magnitude(logic [31:0] raw, output bit neg);
		logic [63:0] m;
		logic [63:0] v;
		m = (DW >= 64) ? '1 : ((64'd1 << DW) - 64'd1);
		v = {32'd0, raw} & m;
		neg = v[DW-1];
		return neg ? ((~v + 64'd1) & m) : v;
	endfunction

	function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	// expected result of one request
	function automatic out_req_t predict_fraction(in_req_t rq);
		out_req_t r;
		bit an_n, ad_n, bn_n, bd_n, sa, sb, xn, yn, nneg, arith;
		logic [63:0] an, ad, bn, bd, xm, ym, nmag, den, g, nm, dm, lim;
		an = magnitude(rq.a_num, an_n);
		ad = magnitude(rq.a_den, ad_n);
		bn = magnitude(rq.b_num, bn_n);
		bd = magnitude(rq.b_den, bd_n);
		r = '0;
		r.order = ORD_EQUAL;
		if (ad == 0 || bd == 0) begin
			r.status = ST_ZERODEN;
			return r;
		end
		sa = (an_n != ad_n) && an != 0;
		sb = (bn_n != bd_n) && bn != 0;
		xn = sa; xm = an * bd;
		yn = sb; ym = bn * ad;
		arith = 1'b1;
		nneg = 1'b0; nmag = 0; den = 0;
		case (rq.mode)
			MODE_ADD, MODE_SUB: begin
				if (rq.mode == MODE_SUB)
					yn = !yn && ym != 0;
				if (xn == yn) begin
					nneg = xn; nmag = xm + ym;
				end else if (xm >= ym) begin
					nneg = xn; nmag = xm - ym;
				end else begin
					nneg = yn; nmag = ym - xm;
				end
				den = ad * bd;
			end
			MODE_MUL: begin
				nneg = sa != sb; nmag = an * bn; den = ad * bd;
			end
			MODE_DIV: begin
				nneg = sa != sb; nmag = an * bd; den = ad * bn;
			end
			default: begin
				// compare, undefined modes included
				arith = 1'b0;
				if (xm == 0) xn = 1'b0;
				if (ym == 0) yn = 1'b0;
				if (xn != yn)
					r.order = xn ? ORD_LESS : ORD_GREATER;
				else if (xm == ym)
					r.order = ORD_EQUAL;
				else if (xm < ym)
					r.order = xn ? ORD_GREATER : ORD_LESS;
				else
					r.order = xn ? ORD_LESS : ORD_GREATER;
			end
		endcase
		if (!arith)
			return r;
		if (rq.mode == MODE_DIV && bn == 0) begin
			r.status = ST_DIVZERO;
		end else if (nmag == 0) begin
			r.res_den = 31'd1;
		end else begin
			g = gcd64(nmag, den);
			lim = 64'd1 << (DW - 1);
			nm = nmag / g;
			dm = den / g;
			if (dm > lim - 1 || (nneg ? nm > lim : nm > lim - 1)) begin
				r.status = ST_OVF;
			end else begin
				r.res_num = nneg ? 32'(64'd0 - nm) : nm[31:0];
				r.res_den = dm[30:0];
			end
		end
		return r;
	endfunction

	// one request on the input channel; valid is only lowered for a real gap
	task automatic send_request(in_req_t rq);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= rq;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_results.push_back(predict_fraction(rq));
	endtask

	task automatic send_fields(mode_t m, logic [31:0] an, logic [31:0] ad,
			logic [31:0] bn, logic [31:0] bd);
		in_req_t rq;
		rq = '{mode: m, a_num: an, a_den: ad, b_num: bn, b_den: bd};
		send_request(rq);
	endtask

	// random value: mostly small magnitudes to keep the GCD short
	function automatic logic [31:0] rand_value(bit nonzero);
		logic [31:0] v;
		case ($urandom_range(0, 9))
			0, 1: v = $urandom;
			2: v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
			default: v = $urandom_range(0, 1000);
		endcase
		if ($urandom_range(0, 1)) v = -v;
		if (nonzero && v == 0) v = 32'd1;
		return v;
	endfunction

	// extremes of the fields and every special case
	task automatic test_directed();
		send_fields(MODE_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
		send_fields(MODE_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
		send_fields(MODE_MUL, -32'sd3, 32'd4, 32'd8, -32'sd9);
		send_fields(MODE_DIV, 32'd3, -32'sd4, 32'd6, 32'd8);
		send_fields(MODE_CMP, 32'd1, 32'd2, -32'sd2, -32'sd4);
		send_fields(MODE_CMP, -32'sd1, 32'd2, 32'd1, 32'd3);
		send_fields(MODE_CMP, 32'd1, 32'd2, 32'd1, 32'd3);
		send_fields(MODE_CMP, 32'd1, 32'd3, 32'd1, 32'd2);
		// zero denominators, compare included
		send_fields(MODE_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
		send_fields(MODE_CMP, 32'd1, 32'd1, 32'd1, 32'd0);
		send_fields(MODE_DIV, 32'd1, 32'd0, 32'd0, 32'd1);
		// divide by a zero fraction
		send_fields(MODE_DIV, 32'd5, 32'd7, 32'd0, -32'sd3);
		// zero result
		send_fields(MODE_MUL, 32'd0, -32'sd7, 32'd5, 32'd3);
		// overflow and the most negative values
		send_fields(MODE_ADD, 32'h7fff_ffff, 32'd1, 32'd1, 32'd1);
		send_fields(MODE_SUB, 32'h8000_0000, 32'd1, 32'd0, 32'd1);
		send_fields(MODE_SUB, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
		send_fields(MODE_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd1);
		send_fields(MODE_DIV, 32'h8000_0000, 32'd1, 32'hffff_ffff, 32'd1);
		send_fields(MODE_MUL, 32'd1, 32'h7fff_ffff, 32'd1, 32'd2);
		send_fields(MODE_ADD, 32'h7fff_ffff, 32'h7ffffffe, 32'h8000_0000, 32'h7fff_fffd);
		// undefined modes behave as compare
		send_fields(mode_t'(3'd5), 32'd1, 32'd2, 32'd1, 32'd3);
		send_fields(mode_t'(3'd6), 32'd2, 32'd4, 32'd1, 32'd2);
		send_fields(mode_t'(3'd7), 32'hffff_ffff, 32'd1, 32'd1, 32'd1);
	endtask

	task automatic test_random(int count);
		in_req_t rq;
		bit zd;
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
			zd = ($urandom_range(0, 19) == 0);
			rq.mode  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(0, 4));
			rq.a_num = rand_value(1'b0);
			rq.a_den = (zd && $urandom_range(0, 1)) ? 32'd0 : rand_value(1'b1);
			rq.b_num = rand_value(1'b0);
			rq.b_den = zd ? 32'd0 : rand_value(1'b1);
			if ($urandom_range(0, 7) == 0) rq.b_num = 32'd0;
			send_request(rq);
		end
		no_idle = 1'b0;
	endtask

	// result side: compare against the oldest prediction, random stalls
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %p", $time, out_data);
				failures++;
			end else begin
				out_req_t e;
				e = expected_results.pop_front();
				if (e.res_num !== out_data.res_num)
					$display("%0t: res_num expected %0d got %0d", $time,
						e.res_num, out_data.res_num);
				if (e.res_den !== out_data.res_den)
					$display("%0t: res_den expected %0d got %0d", $time,
						e.res_den, out_data.res_den);
				if (e.order !== out_data.order)
					$display("%0t: order expected %0d got %0d", $time,
						e.order, out_data.order);
				if (e.status !== out_data.status)
					$display("%0t: status expected %0d got %0d", $time,
						e.status, out_data.status);
				if (e !== out_data) failures++;
			end
			out_stall = no_idle ? 0 : $urandom_range(0, 5);
			if (out_stall > 0) out_ready <= 1'b0;
		end else if (!out_ready) begin
			if (out_stall <= 1) out_ready <= 1'b1;
			out_stall--;
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("rational_arithmetic_unit verification failed");
			$finish;
		end
	end

	initial begin
		failures  = 0;
		quiet_cycles = 0;
		out_stall = 0;
		no_idle   = 1'b0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_ready = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(850);
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("rational_arithmetic_unit verification clean");
		else
			$display("rational_arithmetic_unit verification failed");
		$finish;
	end
endmodule
`default_nettype wire
